// ===== src/tpc_pkg.sv =====
// Shared types and constants for the triangle plane clipper.
package tpc_pkg;

  // Distance width: a floored 32x32 product fits 56 bits at the smallest fraction size,
  // so sums and differences of them fit here
  localparam int DW = 60;
  // Interpolation factor width: covers 1.0 at the largest fraction size
  localparam int TW = 25;
  // Edge delta (33 bits) times zero-extended factor
  localparam int PW = 33 + TW + 1;

  // Configuration register indexes
  localparam logic [2:0] REG_POINT_X  = 3'd0;
  localparam logic [2:0] REG_POINT_Y  = 3'd1;
  localparam logic [2:0] REG_POINT_Z  = 3'd2;
  localparam logic [2:0] REG_NORMAL_X = 3'd3;
  localparam logic [2:0] REG_NORMAL_Y = 3'd4;
  localparam logic [2:0] REG_NORMAL_Z = 3'd5;

  // Three coordinates, index 0 is x
  typedef logic [2:0][31:0] vec_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ALL,
    KIND_TWO,
    KIND_ONE
  } kind_t;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic [15:0]        shade;
    logic [15:0]        glyph;
  } tri_in_t;

  typedef struct packed {
    logic signed [31:0] out_a_x;
    logic signed [31:0] out_a_y;
    logic signed [31:0] out_a_z;
    logic signed [31:0] out_b_x;
    logic signed [31:0] out_b_y;
    logic signed [31:0] out_b_z;
    logic signed [31:0] out_c_x;
    logic signed [31:0] out_c_y;
    logic signed [31:0] out_c_z;
    logic [15:0]        out_shade;
    logic [15:0]        out_glyph;
    logic               last_of_run;
  } tri_out_t;

  // Everything an item carries after classification
  typedef struct packed {
    kind_t           kind;
    vec_t            v0;
    vec_t            v1;
    vec_t            v2;
    vec_t [1:0]      bv;
    vec_t [1:0]      ev;
    logic [15:0]     shade;
    logic [15:0]     glyph;
  } carry_t;

  typedef struct packed {
    carry_t             c;
    logic [1:0][DW-1:0] num;
    logic [1:0][DW-1:0] den;
  } div_in_t;

  typedef struct packed {
    carry_t             c;
    logic [1:0]         zero;
    logic [1:0]         one;
    logic [1:0][TW-1:0] q;
  } div_out_t;

  typedef struct packed {
    carry_t     c;
    vec_t [1:0] x;
  } lerp_out_t;

endpackage

// ===== src/tpc_dist.sv =====
// Plane distances, inside/outside classification and edge selection (four stages).
module tpc_dist #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  tpc_pkg::tri_in_t in_data,
  input  tpc_pkg::vec_t    point,
  input  tpc_pkg::vec_t    normal,
  output logic             out_valid,
  output tpc_pkg::div_in_t out_data
);
  import tpc_pkg::*;

  vec_t                 pts [4];
  logic signed [63:0]   prod [4][3];
  logic signed [63:0]   shp [4][3];
  logic signed [DW-1:0] pr1 [4][3];
  logic signed [DW-1:0] sum2 [4];
  logic signed [DW-1:0] d3 [3];
  tri_in_t              s1, s2, s3;
  logic                 v1, v2, v3, v4;
  div_in_t              s4_next, s4;

  // Form all twelve products, floored to the fixed-point grid
  always_comb begin
    pts[0] = {in_data.a_z, in_data.a_y, in_data.a_x};
    pts[1] = {in_data.b_z, in_data.b_y, in_data.b_x};
    pts[2] = {in_data.c_z, in_data.c_y, in_data.c_x};
    pts[3] = point;
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        prod[j][k] = $signed(pts[j][k]) * $signed(normal[k]);
        shp[j][k]  = prod[j][k] >>> FRAC_BITS;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Products, dot sums, distances
  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= in_data;
      s2 <= s1;
      s3 <= s2;
      s4 <= s4_next;
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          pr1[j][k] <= shp[j][k][DW-1:0];
        end
        sum2[j] <= pr1[j][0] + pr1[j][1] + pr1[j][2];
      end
      for (int i = 0; i < 3; i++) begin
        d3[i] <= sum2[i] - sum2[3];
      end
    end
  end

  // Classify and pick the outside/inside vertex of each clipped edge
  always_comb begin
    vec_t                 vt [3];
    logic [2:0]           ins;
    logic [1:0]           i0, i1, o0, o1, e1;
    kind_t                kind;
    logic signed [DW-1:0] db, de;
    vt[0] = {s3.a_z, s3.a_y, s3.a_x};
    vt[1] = {s3.b_z, s3.b_y, s3.b_x};
    vt[2] = {s3.c_z, s3.c_y, s3.c_x};
    for (int i = 0; i < 3; i++) begin
      ins[i] = ~d3[i][DW-1];
    end
    i0 = 2'd0; i1 = 2'd1; o0 = 2'd2; o1 = 2'd2; e1 = 2'd1;
    kind = KIND_NONE;
    case (ins)
      3'b111: begin kind = KIND_ALL; end
      3'b011: begin kind = KIND_TWO; i0 = 2'd0; i1 = 2'd1; o0 = 2'd2; o1 = 2'd2; e1 = 2'd1; end
      3'b101: begin kind = KIND_TWO; i0 = 2'd0; i1 = 2'd2; o0 = 2'd1; o1 = 2'd1; e1 = 2'd2; end
      3'b110: begin kind = KIND_TWO; i0 = 2'd1; i1 = 2'd2; o0 = 2'd0; o1 = 2'd0; e1 = 2'd2; end
      3'b001: begin kind = KIND_ONE; i0 = 2'd0; o0 = 2'd1; o1 = 2'd2; e1 = 2'd0; end
      3'b010: begin kind = KIND_ONE; i0 = 2'd1; o0 = 2'd0; o1 = 2'd2; e1 = 2'd1; end
      3'b100: begin kind = KIND_ONE; i0 = 2'd2; o0 = 2'd0; o1 = 2'd1; e1 = 2'd2; end
      default: begin kind = KIND_NONE; end
    endcase
    s4_next.c.kind  = kind;
    s4_next.c.v0    = vt[i0];
    s4_next.c.v1    = vt[i1];
    s4_next.c.v2    = vt[2];
    s4_next.c.bv[0] = vt[o0];
    s4_next.c.ev[0] = vt[i0];
    s4_next.c.bv[1] = vt[o1];
    s4_next.c.ev[1] = vt[e1];
    s4_next.c.shade = s3.shade;
    s4_next.c.glyph = s3.glyph;
    db = d3[o0];
    de = d3[i0];
    s4_next.num[0] = -db;
    s4_next.den[0] = de - db;
    db = d3[o1];
    de = d3[e1];
    s4_next.num[1] = -db;
    s4_next.den[1] = de - db;
  end

  assign out_valid = v4;
  assign out_data  = s4;

endmodule

// ===== src/tpc_div.sv =====
// Pipelined restoring divider for both clipped edges, one quotient bit per stage.
module tpc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  tpc_pkg::div_in_t  in_data,
  output logic              out_valid,
  output tpc_pkg::div_out_t out_data
);
  import tpc_pkg::*;

  typedef struct packed {
    carry_t             c;
    logic [1:0]         zero;
    logic [1:0]         one;
    logic [1:0][DW:0]   r;
    logic [1:0][DW-1:0] den;
    logic [1:0][TW-1:0] q;
  } dstage_t;

  dstage_t sd [FRAC_BITS+1];
  logic    sv [FRAC_BITS+1];
  dstage_t front;

  // Produce one quotient bit per lane
  function automatic dstage_t div_step(input dstage_t s);
    dstage_t   n;
    logic [DW:0] r2;
    n = s;
    for (int l = 0; l < 2; l++) begin
      r2 = {s.r[l][DW-1:0], 1'b0};
      if (r2 >= {1'b0, s.den[l]}) begin
        n.r[l] = r2 - {1'b0, s.den[l]};
        n.q[l] = {s.q[l][TW-2:0], 1'b1};
      end else begin
        n.r[l] = r2;
        n.q[l] = {s.q[l][TW-2:0], 1'b0};
      end
    end
    return n;
  endfunction

  // Sort out the trivial quotients before the steps
  always_comb begin
    front.c = in_data.c;
    for (int l = 0; l < 2; l++) begin
      front.zero[l] = ($signed(in_data.num[l]) <= 0) || ($signed(in_data.den[l]) <= 0);
      front.one[l]  = $signed(in_data.num[l]) >= $signed(in_data.den[l]);
      front.r[l]    = {1'b0, in_data.num[l]};
      front.den[l]  = in_data.den[l];
      front.q[l]    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= front;
    end
  end

  for (genvar g = 1; g <= FRAC_BITS; g++) begin : g_step
    // Advance one quotient bit
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[g] <= 1'b0;
      end else if (en) begin
        sv[g] <= sv[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[g] <= div_step(sd[g-1]);
      end
    end
  end

  assign out_valid     = sv[FRAC_BITS];
  assign out_data.c    = sd[FRAC_BITS].c;
  assign out_data.zero = sd[FRAC_BITS].zero;
  assign out_data.one  = sd[FRAC_BITS].one;
  assign out_data.q    = sd[FRAC_BITS].q;

endmodule

// ===== src/tpc_lerp.sv =====
// Intersection points b + (e - b) * t, saturated (three stages).
module tpc_lerp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  tpc_pkg::div_out_t  in_data,
  output logic               out_valid,
  output tpc_pkg::lerp_out_t out_data
);
  import tpc_pkg::*;

  carry_t             ca, cb, cc;
  logic               va, vb, vc;
  logic [1:0][TW-1:0] ta;
  logic signed [32:0] da [2][3];
  logic signed [PW-1:0] pb [2][3];
  vec_t [1:0]         xc, xc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  // Final factor and edge deltas, then products
  always_ff @(posedge clk) begin
    if (en) begin
      ca <= in_data.c;
      cb <= ca;
      cc <= cb;
      xc <= xc_next;
      for (int l = 0; l < 2; l++) begin
        if (in_data.zero[l]) begin
          ta[l] <= '0;
        end else if (in_data.one[l]) begin
          ta[l] <= TW'(1) << FRAC_BITS;
        end else begin
          ta[l] <= in_data.q[l];
        end
        for (int k = 0; k < 3; k++) begin
          da[l][k] <= $signed({in_data.c.ev[l][k][31], in_data.c.ev[l][k]})
                    - $signed({in_data.c.bv[l][k][31], in_data.c.bv[l][k]});
          pb[l][k] <= da[l][k] * $signed({1'b0, ta[l]});
        end
      end
    end
  end

  // Add the floored offset to the outside vertex and clamp
  always_comb begin
    logic signed [PW-1:0] sh;
    logic signed [34:0]   sum;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        sh  = pb[l][k] >>> FRAC_BITS;
        sum = $signed({{3{cb.bv[l][k][31]}}, cb.bv[l][k]}) + sh[34:0];
        if (sum > 35'sd2147483647) begin
          xc_next[l][k] = 32'h7fff_ffff;
        end else if (sum < -35'sd2147483648) begin
          xc_next[l][k] = 32'h8000_0000;
        end else begin
          xc_next[l][k] = sum[31:0];
        end
      end
    end
  end

  assign out_valid  = vc;
  assign out_data.c = cc;
  assign out_data.x = xc;

endmodule

// ===== src/triangle_plane_clipper.sv =====
// Top level of the triangle plane clipper: config registers, pipeline, result buffer.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_ready  | in_data  (tri_in_t, one triangle)
//  out     | out_valid/ out_ready | out_data (tri_out_t, one triangle)
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// The pipeline has 4 distance stages, FRAC_BITS + 1 divider stages,
// 3 interpolation stages and the result buffer. A triangle that yields two
// results holds the result buffer until both are sent, since it sends one
// triangle a beat. A stall at out_ready freezes the whole pipeline once a
// visible result waits at the tail; triangles wholly clipped away drain regardless.
// Synchronous reset clears valid bits and loads the default plane.
module triangle_plane_clipper #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpc_pkg::tri_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tpc_pkg::tri_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import tpc_pkg::*;

  vec_t      cfg_point, cfg_normal;
  logic      en;
  logic      dv, qv, lv;
  div_in_t   dd;
  div_out_t  qd;
  lerp_out_t ld;
  tri_out_t  res0, res1, res0_next, res1_next;
  logic      em_valid, em_sel, em_two;
  logic      em_last, em_free, load;

  // Hold plane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_point  <= {32'sd6554, 32'sd0, 32'sd0};
      cfg_normal <= {32'sd65536, 32'sd0, 32'sd0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_X:  cfg_point[0]  <= cfg_data;
        REG_POINT_Y:  cfg_point[1]  <= cfg_data;
        REG_POINT_Z:  cfg_point[2]  <= cfg_data;
        REG_NORMAL_X: cfg_normal[0] <= cfg_data;
        REG_NORMAL_Y: cfg_normal[1] <= cfg_data;
        REG_NORMAL_Z: cfg_normal[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless a visible result is blocked at the tail
  assign em_last  = em_valid && (!em_two || em_sel);
  assign em_free  = !em_valid || (out_ready && em_last);
  assign en       = !lv || (ld.c.kind == KIND_NONE) || em_free;
  assign load     = lv && (ld.c.kind != KIND_NONE) && em_free;
  assign in_ready = en;

  tpc_dist #(.FRAC_BITS(FRAC_BITS)) u_dist (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .in_data(in_data),
    .point(cfg_point), .normal(cfg_normal),
    .out_valid(dv), .out_data(dd)
  );

  tpc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(dv), .in_data(dd),
    .out_valid(qv), .out_data(qd)
  );

  tpc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(qv), .in_data(qd),
    .out_valid(lv), .out_data(ld)
  );

  function automatic tri_out_t make_tri(input vec_t p0, input vec_t p1, input vec_t p2,
                                        input logic [15:0] shade, input logic [15:0] glyph,
                                        input logic last);
    tri_out_t t;
    t.out_a_x = p0[0]; t.out_a_y = p0[1]; t.out_a_z = p0[2];
    t.out_b_x = p1[0]; t.out_b_y = p1[1]; t.out_b_z = p1[2];
    t.out_c_x = p2[0]; t.out_c_y = p2[1]; t.out_c_z = p2[2];
    t.out_shade   = shade;
    t.out_glyph   = glyph;
    t.last_of_run = last;
    return t;
  endfunction

  // Assemble the result triangles of the tail item
  always_comb begin
    res0_next = make_tri(ld.c.v0, ld.c.v1, ld.c.v2, ld.c.shade, ld.c.glyph, 1'b1);
    res1_next = make_tri(ld.c.v1, ld.x[1], ld.x[0], ld.c.shade, ld.c.glyph, 1'b1);
    case (ld.c.kind)
      KIND_TWO: res0_next = make_tri(ld.c.v0, ld.c.v1, ld.x[0], ld.c.shade, ld.c.glyph, 1'b0);
      KIND_ONE: res0_next = make_tri(ld.c.v0, ld.x[0], ld.x[1], ld.c.shade, ld.c.glyph, 1'b1);
      default: ;
    endcase
  end

  // Result buffer: hold up to two triangles, send one a beat
  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
      em_sel   <= 1'b0;
      em_two   <= 1'b0;
    end else if (load) begin
      em_valid <= 1'b1;
      em_sel   <= 1'b0;
      em_two   <= (ld.c.kind == KIND_TWO);
    end else if (em_valid && out_ready) begin
      if (em_last) begin
        em_valid <= 1'b0;
        em_sel   <= 1'b0;
      end else begin
        em_sel <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res0 <= res0_next;
      res1 <= res1_next;
    end
  end

  assign out_valid = em_valid;
  assign out_data  = em_sel ? res1 : res0;

  a_sel_two: assert property (@(posedge clk) disable iff (rst)
    em_sel |-> (em_valid && em_two))
    else $error("second triangle selected without a pair");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last_of_run) |=> (out_valid && em_sel))
    else $error("second triangle of a pair missing");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (lv && em_valid && (ld.c.kind != KIND_NONE)))
    else $error("pipeline stalled without a blocked result");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (em_valid && !out_ready) |=> (em_valid && $stable(em_sel)))
    else $error("result buffer changed while stalled");

endmodule

// ===== dv/triangle_plane_clipper_tb.sv =====
// Self-checking testbench for the triangle plane clipper.
`timescale 1ns / 1ps

module triangle_plane_clipper_tb;
  import tpc_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 9;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  tri_in_t in_data;
  logic out_valid;
  logic out_ready;
  tri_out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  // Plane as the clipper should see it
  logic signed [31:0] plane_pt [3];
  logic signed [31:0] plane_nrm [3];

  tri_out_t clipped_q [$];
  int errors;
  int rx_mode;        // 0 random stalls, 1 always ready, 2 long hold-off
  int tx_idle_on;

  triangle_plane_clipper #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floored shift of an exact product
  function automatic longint floor_q(longint v);
    return v >>> FRAC;
  endfunction

  function automatic longint plane_dot(longint x, longint y, longint z);
    return floor_q(longint'(plane_nrm[0]) * x) + floor_q(longint'(plane_nrm[1]) * y)
         + floor_q(longint'(plane_nrm[2]) * z);
  endfunction

  function automatic logic signed [31:0] sat_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Point on the edge from outside vertex b towards inside vertex e
  function automatic void edge_cross(input longint b[3], input longint db,
                                     input longint e[3], input longint de,
                                     output longint res[3]);
    longint num, den, t, r;
    num = -db;
    den = de - db;
    t = 0;
    if (num > 0 && den > 0) begin
      if (num >= den) t = longint'(1) << FRAC;
      else begin
        r = num;
        for (int k = 0; k < FRAC; k++) begin
          r = r * 2;
          t = t * 2;
          if (r >= den) begin
            r = r - den;
            t = t + 1;
          end
        end
      end
    end
    for (int k = 0; k < 3; k++) res[k] = longint'(sat_word(b[k] + floor_q((e[k] - b[k]) * t)));
  endfunction

  function automatic tri_out_t make_tri(longint p0[3], longint p1[3], longint p2[3],
                                        tri_in_t src, logic last);
    tri_out_t o;
    o.out_a_x = 32'(p0[0]); o.out_a_y = 32'(p0[1]); o.out_a_z = 32'(p0[2]);
    o.out_b_x = 32'(p1[0]); o.out_b_y = 32'(p1[1]); o.out_b_z = 32'(p1[2]);
    o.out_c_x = 32'(p2[0]); o.out_c_y = 32'(p2[1]); o.out_c_z = 32'(p2[2]);
    o.out_shade = src.shade;
    o.out_glyph = src.glyph;
    o.last_of_run = last;
    return o;
  endfunction

  // Append one triangle to the expected list
  function automatic void queue_tri(tri_out_t o);
    clipped_q = {clipped_q, o};
  endfunction

  // Queue the clipped triangles that one input triangle yields
  task automatic clip_predict(tri_in_t t);
    longint v[3][3];
    longint sdist[3];
    longint dp;
    longint x0[3], x1[3];
    int ins[3], outs[3];
    int nin, nout;
    nin = 0;
    nout = 0;
    v[0] = '{t.a_x, t.a_y, t.a_z};
    v[1] = '{t.b_x, t.b_y, t.b_z};
    v[2] = '{t.c_x, t.c_y, t.c_z};
    dp = plane_dot(plane_pt[0], plane_pt[1], plane_pt[2]);
    for (int i = 0; i < 3; i++) begin
      sdist[i] = plane_dot(v[i][0], v[i][1], v[i][2]) - dp;
      if (sdist[i] >= 0) begin
        ins[nin] = i;
        nin = nin + 1;
      end else begin
        outs[nout] = i;
        nout = nout + 1;
      end
    end
    if (nin == 3) begin
      queue_tri(make_tri(v[0], v[1], v[2], t, 1'b1));
    end else if (nin == 2) begin
      edge_cross(v[outs[0]], sdist[outs[0]], v[ins[0]], sdist[ins[0]], x0);
      edge_cross(v[outs[0]], sdist[outs[0]], v[ins[1]], sdist[ins[1]], x1);
      queue_tri(make_tri(v[ins[0]], v[ins[1]], x0, t, 1'b0));
      queue_tri(make_tri(v[ins[1]], x1, x0, t, 1'b1));
    end else if (nin == 1) begin
      edge_cross(v[outs[0]], sdist[outs[0]], v[ins[0]], sdist[ins[0]], x0);
      edge_cross(v[outs[1]], sdist[outs[1]], v[ins[0]], sdist[ins[0]], x1);
      queue_tri(make_tri(v[ins[0]], x0, x1, t, 1'b1));
    end
  endtask

  // Offer one triangle, hold until the beat is taken
  task automatic send_tri(tri_in_t t);
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    clip_predict(t);
    if (tx_idle_on != 0 && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Drive one register write; the caller drops the write enable afterwards
  task automatic write_reg(logic [2:0] idx, logic signed [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_POINT_X:  plane_pt[0] = val;
      REG_POINT_Y:  plane_pt[1] = val;
      REG_POINT_Z:  plane_pt[2] = val;
      REG_NORMAL_X: plane_nrm[0] = val;
      REG_NORMAL_Y: plane_nrm[1] = val;
      REG_NORMAL_Z: plane_nrm[2] = val;
      default: ;
    endcase
  endtask

  task automatic set_plane(logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz, logic signed [31:0] nx,
                           logic signed [31:0] ny, logic signed [31:0] nz);
    write_reg(REG_POINT_X, px);
    write_reg(REG_POINT_Y, py);
    write_reg(REG_POINT_Z, pz);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    cfg_we <= 1'b0;
  endtask

  // Mostly modest coordinates so clipping is meaningful, sometimes full range
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  function automatic tri_in_t rand_tri();
    tri_in_t t;
    t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
    t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
    t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
    t.shade = $urandom;
    t.glyph = $urandom;
    return t;
  endfunction

  function automatic tri_in_t tri_z(int za, int zb, int zc);
    tri_in_t t;
    t = rand_tri();
    t.a_z = za; t.b_z = zb; t.c_z = zc;
    return t;
  endfunction

  // Default plane z >= 0.1: every inside count, order and degenerate edge
  task automatic test_directed();
    tri_in_t t;
    send_tri(tri_z(65536, 65536, 65536));
    send_tri(tri_z(-65536, -65536, -65536));
    send_tri(tri_z(65536, 65536, -65536));
    send_tri(tri_z(65536, -65536, 65536));
    send_tri(tri_z(-65536, 65536, 65536));
    send_tri(tri_z(65536, -65536, -65536));
    send_tri(tri_z(-65536, 65536, -65536));
    send_tri(tri_z(-65536, -65536, 65536));
    send_tri(tri_z(6554, 6553, 6554));
    t = tri_z(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    t.a_x = 32'sh7fffffff; t.b_x = 32'sh80000000; t.shade = 16'hffff; t.glyph = 16'h0000;
    send_tri(t);
    t = tri_z(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    t.b_y = 32'sh80000000; t.c_y = 32'sh7fffffff; t.shade = 16'h0000; t.glyph = 16'hffff;
    send_tri(t);
    drain_all();
    // Zero normal: everything passes
    set_plane(32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0);
    send_tri(tri_z(-65536, 65536, 32'sh80000000));
    drain_all();
    // Extreme normals and point: saturating interpolation
    set_plane(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    for (int i = 0; i < 8; i++) send_tri(rand_tri());
    drain_all();
  endtask

  task automatic random_plane();
    set_plane(rand_coord(), rand_coord(), rand_coord(),
              $urandom_range(0, 4) == 0 ? $urandom : rand_coord(),
              $urandom_range(0, 4) == 0 ? $urandom : rand_coord(),
              $urandom_range(0, 4) == 0 ? $urandom : rand_coord());
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      random_plane();
      for (int i = 0; i < per_phase; i++) send_tri(rand_tri());
      drain_all();
    end
  endtask

  // Receiver holds off for a long pause while the sender keeps offering
  task automatic test_backpressure();
    rx_mode = 2;
    tx_idle_on = 0;
    for (int i = 0; i < 60; i++) send_tri(tri_z(65536, -65536, 65536));
    rx_mode = 0;
    tx_idle_on = 1;
    drain_all();
  endtask

  task automatic test_streaming();
    rx_mode = 1;
    tx_idle_on = 0;
    random_plane();
    for (int i = 0; i < 200; i++) send_tri(rand_tri());
    drain_all();
  endtask

  // Receiver readiness
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (rx_mode == 2) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
        while (rx_mode == 2) @(posedge clk);
      end else if (rx_mode == 0 && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result beat with the oldest expected triangle
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (clipped_q.size() == 0) begin
        $display("%0t unexpected triangle: expected none actual %h", $time, out_data);
        errors++;
      end else begin
        if (out_data !== clipped_q[0]) begin
          $display("%0t triangle mismatch: expected %h actual %h",
                   $time, clipped_q[0], out_data);
          errors++;
        end
        void'(clipped_q.pop_front());
      end
    end
  end

  initial begin
    errors = 0;
    rx_mode = 0;
    tx_idle_on = 1;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_POINT_X;
    cfg_data = '0;
    plane_pt = '{0, 0, 6554};
    plane_nrm = '{0, 0, 65536};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(12, 98);
    test_backpressure();
    test_streaming();
    if (clipped_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
